// ===== design/tpam_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpam_pkg - shared types and constants of the touch press affine mapper
// Field widths, calibration register codes and the structs that travel
// between the front end, the job queue and the mapping back end.
// ----------------------------------------------------------------------------
package tpam_pkg;

	// field widths
	localparam int RAW_W     = 12;
	localparam int COORD_W   = 16;
	localparam int COEF_W    = 32;
	localparam int REG_IDX_W = 3;

	// coef * raw product, raw taken as a positive signed value
	localparam int PROD_W  = COEF_W + RAW_W + 1;
	// two products plus an offset
	localparam int NUM_W   = PROD_W + 2;
	// quotient bits kept: one beyond the coordinate to see saturation
	localparam int QUO_W   = COORD_W + 1;
	localparam int QSTEP_W = $clog2(QUO_W);

	// default depth of the job queue between front and back
	localparam int JOB_DEPTH_DEF = 2;

	// calibration register indexes
	localparam logic [REG_IDX_W-1:0] REG_COEF_XX  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COEF_XY  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_X = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COEF_YX  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COEF_YY  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_DIVISOR  = 3'd6;

	localparam logic [COEF_W-1:0] DIVISOR_RST = 32'd1;

	// saturation limits of a coordinate
	localparam logic [COORD_W-1:0] COORD_MAX = 16'h7fff;
	localparam logic [COORD_W-1:0] COORD_MIN = 16'h8000;

	// one mapping job: the raw point taken on a new press
	typedef struct packed {
		logic [RAW_W-1:0] raw_x;
		logic [RAW_W-1:0] raw_y;
	} job_t;

	// calibration register file, all fields two's complement
	typedef struct packed {
		logic [COEF_W-1:0] coef_xx;
		logic [COEF_W-1:0] coef_xy;
		logic [COEF_W-1:0] offset_x;
		logic [COEF_W-1:0] coef_yx;
		logic [COEF_W-1:0] coef_yy;
		logic [COEF_W-1:0] offset_y;
		logic [COEF_W-1:0] divisor;
	} cal_t;

endpackage

// ===== design/touch_press_affine_mapper_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_press_affine_mapper_unit - touch press tracker with affine mapping
// Poll beats enter through push/full. A poll beat is held off only while
// the tracker is idle and the job queue is full. A new press queues a job;
// the back end maps it (a restoring division of 17 quotient bits per axis
// on one shared divider, plus multiply, sign and saturation steps), and
// the job queue holds JOB_DEPTH presses ahead of it. Results leave
// through empty/pop and one finished result is held while the next press
// is worked on. A zero divisor gives a fault result with zero
// coordinates. Calibration registers are written through
// cfg_we/cfg_idx/cfg_wdata; indexes past the last register are ignored.
// ----------------------------------------------------------------------------
module touch_press_affine_mapper_unit #(
	parameter int JOB_DEPTH = tpam_pkg::JOB_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic                            pen_down,
	input  logic [tpam_pkg::RAW_W-1:0]      raw_x,
	input  logic [tpam_pkg::RAW_W-1:0]      raw_y,
	output logic                            empty,
	input  logic                            pop,
	output logic [tpam_pkg::COORD_W-1:0]    screen_x,
	output logic [tpam_pkg::COORD_W-1:0]    screen_y,
	output logic                            divide_fault,
	input  logic                            cfg_we,
	input  logic [tpam_pkg::REG_IDX_W-1:0]  cfg_idx,
	input  logic [tpam_pkg::COEF_W-1:0]     cfg_wdata
);

	tpam_pkg::cal_t  cal_q;
	tpam_pkg::job_t  front_job;
	tpam_pkg::job_t  queue_job;
	logic            job_push;
	logic            job_pop;
	logic            q_full;
	logic            q_empty;

	// calibration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '{
				coef_xx:  '0,
				coef_xy:  '0,
				offset_x: '0,
				coef_yx:  '0,
				coef_yy:  '0,
				offset_y: '0,
				divisor:  tpam_pkg::DIVISOR_RST
			};
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tpam_pkg::REG_COEF_XX:  cal_q.coef_xx  <= cfg_wdata;
				tpam_pkg::REG_COEF_XY:  cal_q.coef_xy  <= cfg_wdata;
				tpam_pkg::REG_OFFSET_X: cal_q.offset_x <= cfg_wdata;
				tpam_pkg::REG_COEF_YX:  cal_q.coef_yx  <= cfg_wdata;
				tpam_pkg::REG_COEF_YY:  cal_q.coef_yy  <= cfg_wdata;
				tpam_pkg::REG_OFFSET_Y: cal_q.offset_y <= cfg_wdata;
				tpam_pkg::REG_DIVISOR:  cal_q.divisor  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// press tracking
	tpam_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.pen_down (pen_down),
		.raw_x    (raw_x),
		.raw_y    (raw_y),
		.q_full   (q_full),
		.job_push (job_push),
		.job      (front_job)
	);

	// jobs waiting for the mapper
	tpam_job_q #(
		.DEPTH (JOB_DEPTH)
	) u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_job  (front_job),
		.rd_en   (job_pop),
		.rd_job  (queue_job),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	// affine mapping
	tpam_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cal          (cal_q),
		.job_empty    (q_empty),
		.job          (queue_job),
		.job_pop      (job_pop),
		.empty        (empty),
		.pop          (pop),
		.screen_x     (screen_x),
		.screen_y     (screen_y),
		.divide_fault (divide_fault)
	);

endmodule

// ===== design/tpam_job_q.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpam_job_q - short job queue between front and back
// Register-based first-in first-out store of raw points waiting to be
// mapped. Depth must be at least two.
// ----------------------------------------------------------------------------
module tpam_job_q #(
	parameter int DEPTH = tpam_pkg::JOB_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  tpam_pkg::job_t wr_job,
	input  logic           rd_en,
	output tpam_pkg::job_t rd_job,
	output logic           q_full,
	output logic           q_empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	tpam_pkg::job_t    mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign q_full  = (cnt_q == CNT_W'(DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_job  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// fill count never runs past the depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("job queue count beyond depth");

endmodule

// ===== design/tpam_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpam_front - press tracker
// Takes one poll beat per accepted push, steps the idle / pressing / held
// tracker and queues a mapping job on every new press.
// ----------------------------------------------------------------------------
module tpam_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        pen_down,
	input  logic [tpam_pkg::RAW_W-1:0]  raw_x,
	input  logic [tpam_pkg::RAW_W-1:0]  raw_y,
	input  logic                        q_full,
	output logic                        job_push,
	output tpam_pkg::job_t              job
);

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_PRESSING = 2'd1,
		PH_HELD     = 2'd2
	} phase_t;

	phase_t phase_q;
	logic   accept;

	// only a press needs queue room, so only idle waits on it
	assign full     = q_full && (phase_q == PH_IDLE);
	assign accept   = push && !full;
	assign job_push = accept && pen_down && (phase_q == PH_IDLE);
	assign job      = '{raw_x: raw_x, raw_y: raw_y};

	// press tracker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (accept) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (pen_down) begin
						phase_q <= PH_PRESSING;
					end
				end
				PH_PRESSING: begin
					phase_q <= pen_down ? PH_HELD : PH_IDLE;
				end
				PH_HELD: begin
					if (!pen_down) begin
						phase_q <= PH_IDLE;
					end
				end
				default: begin
					// unused code acts like held
					if (!pen_down) begin
						phase_q <= PH_IDLE;
					end
				end
			endcase
		end
	end

	// a queued press always leaves the tracker in pressing
	a_press_phase: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |=> (phase_q == PH_PRESSING))
		else $error("press queued without entering pressing");

endmodule

// ===== design/tpam_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpam_back - affine mapping engine
// Per job: for each axis a shared 32x13 multiplier builds the numerator,
// then a restoring divider produces 17 quotient bits one per cycle, and
// the result is saturated to 16 bits. Holds one finished result.
// ----------------------------------------------------------------------------
module tpam_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tpam_pkg::cal_t                cal,
	input  logic                          job_empty,
	input  tpam_pkg::job_t                job,
	output logic                          job_pop,
	output logic                          empty,
	input  logic                          pop,
	output logic [tpam_pkg::COORD_W-1:0]  screen_x,
	output logic [tpam_pkg::COORD_W-1:0]  screen_y,
	output logic                          divide_fault
);

	localparam int COEF_W  = tpam_pkg::COEF_W;
	localparam int RAW_W   = tpam_pkg::RAW_W;
	localparam int PROD_W  = tpam_pkg::PROD_W;
	localparam int NUM_W   = tpam_pkg::NUM_W;
	localparam int QUO_W   = tpam_pkg::QUO_W;
	localparam int QSTEP_W = tpam_pkg::QSTEP_W;
	localparam int COORD_W = tpam_pkg::COORD_W;
	localparam int HI_W    = NUM_W - QUO_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_A,
		S_MUL_B,
		S_SUM,
		S_MAG,
		S_PREP,
		S_DIV,
		S_AXIS,
		S_OUT
	} state_t;

	state_t                    state_q;
	logic                      axis_q;
	tpam_pkg::job_t            job_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [NUM_W-1:0]   acc_q;
	logic [NUM_W-1:0]          mag_q;
	logic [COEF_W-1:0]         dk_q;
	logic                      neg_q;
	logic                      ovf_q;
	logic [COEF_W-1:0]         rem_q;
	logic [QUO_W-1:0]          quo_q;
	logic [QSTEP_W-1:0]        step_q;
	logic [COORD_W-1:0]        res_x_q;
	logic [COORD_W-1:0]        res_y_q;
	logic                      fault_q;
	logic                      out_valid_q;
	logic [COORD_W-1:0]        out_x_q;
	logic [COORD_W-1:0]        out_y_q;
	logic                      out_fault_q;

	logic [COEF_W-1:0]         coef_a;
	logic [COEF_W-1:0]         coef_b;
	logic [COEF_W-1:0]         offset;
	logic [COEF_W-1:0]         mul_coef;
	logic [RAW_W-1:0]          mul_raw;
	logic signed [PROD_W-1:0]  mul_out;
	logic [HI_W-1:0]           mag_hi;
	logic [QUO_W-1:0]          mag_lo;
	logic [COEF_W:0]           trial;
	logic [COEF_W:0]           trial_diff;
	logic                      trial_ge;
	logic [COORD_W-1:0]        sat_val;

	// saturate a sign and quotient magnitude to a signed coordinate
	function automatic logic [COORD_W-1:0] sat_coord(input logic ovf, input logic neg,
			input logic [QUO_W-1:0] q);
		logic [QUO_W-1:0] nq;
		logic [COORD_W-1:0] r;
		nq = '0 - q;
		if (ovf) begin
			r = neg ? tpam_pkg::COORD_MIN : tpam_pkg::COORD_MAX;
		end else if (!neg) begin
			r = (q > QUO_W'(tpam_pkg::COORD_MAX)) ? tpam_pkg::COORD_MAX : q[COORD_W-1:0];
		end else begin
			r = (q > QUO_W'(tpam_pkg::COORD_MIN)) ? tpam_pkg::COORD_MIN : nq[COORD_W-1:0];
		end
		return r;
	endfunction

	// coefficient selection for the current axis
	assign coef_a = axis_q ? cal.coef_yx  : cal.coef_xx;
	assign coef_b = axis_q ? cal.coef_yy  : cal.coef_xy;
	assign offset = axis_q ? cal.offset_y : cal.offset_x;

	// shared multiplier, raw sample taken as positive
	assign mul_coef = (state_q == S_MUL_A) ? coef_a : coef_b;
	assign mul_raw  = (state_q == S_MUL_A) ? job_q.raw_x : job_q.raw_y;
	assign mul_out  = $signed(mul_coef) * $signed({1'b0, mul_raw});

	// one restoring division step
	assign mag_hi     = mag_q[NUM_W-1:QUO_W];
	assign mag_lo     = mag_q[QUO_W-1:0];
	assign trial      = {rem_q, mag_lo[step_q]};
	assign trial_diff = trial - {1'b0, dk_q};
	assign trial_ge   = (trial >= {1'b0, dk_q});

	assign sat_val = sat_coord(ovf_q, neg_q, quo_q);

	assign job_pop      = (state_q == S_IDLE) && !job_empty;
	assign empty        = !out_valid_q;
	assign screen_x     = out_x_q;
	assign screen_y     = out_y_q;
	assign divide_fault = out_fault_q;

	// sequencer with datapath and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= 1'b0;
			job_q       <= '0;
			prod_q      <= '0;
			acc_q       <= '0;
			mag_q       <= '0;
			dk_q        <= '0;
			neg_q       <= 1'b0;
			ovf_q       <= 1'b0;
			rem_q       <= '0;
			quo_q       <= '0;
			step_q      <= '0;
			res_x_q     <= '0;
			res_y_q     <= '0;
			fault_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_fault_q <= 1'b0;
		end else begin
			// output beat: filled from the finished result, cleared when taken
			if (state_q == S_OUT && (!out_valid_q || pop)) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!job_empty) begin
						job_q  <= job;
						axis_q <= 1'b0;
						if (cal.divisor == '0) begin
							res_x_q <= '0;
							res_y_q <= '0;
							fault_q <= 1'b1;
							state_q <= S_OUT;
						end else begin
							fault_q <= 1'b0;
							state_q <= S_MUL_A;
						end
					end
				end
				S_MUL_A: begin
					prod_q  <= mul_out;
					state_q <= S_MUL_B;
				end
				S_MUL_B: begin
					acc_q   <= NUM_W'(prod_q) + NUM_W'($signed(offset));
					prod_q  <= mul_out;
					state_q <= S_SUM;
				end
				S_SUM: begin
					acc_q   <= acc_q + NUM_W'(prod_q);
					state_q <= S_MAG;
				end
				S_MAG: begin
					// work on magnitudes, keep the quotient sign
					mag_q   <= acc_q[NUM_W-1] ? NUM_W'(-acc_q) : NUM_W'(acc_q);
					dk_q    <= cal.divisor[COEF_W-1] ? ('0 - cal.divisor) : cal.divisor;
					neg_q   <= acc_q[NUM_W-1] ^ cal.divisor[COEF_W-1];
					state_q <= S_PREP;
				end
				S_PREP: begin
					// quotient of 2^17 or more saturates outright
					ovf_q  <= (COEF_W'(mag_hi) >= dk_q);
					rem_q  <= COEF_W'(mag_hi);
					quo_q  <= '0;
					step_q <= QSTEP_W'(QUO_W - 1);
					state_q <= (COEF_W'(mag_hi) >= dk_q) ? S_AXIS : S_DIV;
				end
				S_DIV: begin
					rem_q <= trial_ge ? trial_diff[COEF_W-1:0] : trial[COEF_W-1:0];
					quo_q <= {quo_q[QUO_W-2:0], trial_ge};
					if (step_q == '0) begin
						state_q <= S_AXIS;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				S_AXIS: begin
					if (!axis_q) begin
						res_x_q <= sat_val;
						axis_q  <= 1'b1;
						state_q <= S_MUL_A;
					end else begin
						res_y_q <= sat_val;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || pop) begin
						out_x_q     <= res_x_q;
						out_y_q     <= res_y_q;
						out_fault_q <= fault_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a fault beat carries zero coordinates
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && divide_fault) |-> (screen_x == '0 && screen_y == '0))
		else $error("fault result with nonzero coordinates");

	// restoring divider keeps its remainder below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < dk_q))
		else $error("divider remainder not below divisor");

	// a taken job starts either the multiply chain or a fault result
	a_job_start: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> (state_q == S_MUL_A || state_q == S_OUT))
		else $error("job taken without starting work");

endmodule

// ===== bench/tpam_press_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpam_press_checker - press tracker and mapping predictor for the bench
// Watches the poll, result and calibration ports of the mapper. It keeps
// its own copy of the calibration registers and the press phase, works
// out the screen point of every new press and compares each popped
// result beat with the oldest point still due.
// ----------------------------------------------------------------------------
module tpam_press_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic                            full,
	input  logic                            pen_down,
	input  logic [tpam_pkg::RAW_W-1:0]      raw_x,
	input  logic [tpam_pkg::RAW_W-1:0]      raw_y,
	input  logic                            empty,
	input  logic                            pop,
	input  logic [tpam_pkg::COORD_W-1:0]    screen_x,
	input  logic [tpam_pkg::COORD_W-1:0]    screen_y,
	input  logic                            divide_fault,
	input  logic                            cfg_we,
	input  logic [tpam_pkg::REG_IDX_W-1:0]  cfg_idx,
	input  logic [tpam_pkg::COEF_W-1:0]     cfg_wdata,
	output int                              fail_count,
	output int                              due_count
);

	localparam int RAW_W   = tpam_pkg::RAW_W;
	localparam int COORD_W = tpam_pkg::COORD_W;
	localparam int COEF_W  = tpam_pkg::COEF_W;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_PRESSING = 2'd1,
		PH_HELD     = 2'd2
	} press_ph_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               fault;
	} coord_t;

	tpam_pkg::cal_t cal_copy;
	press_ph_t      phase;
	coord_t         coords_due[$];
	int             bad;

	// one axis: exact numerator, truncating divide, clamp to 16 bits
	function automatic logic [COORD_W-1:0] scale_axis(
		input logic [COEF_W-1:0] cx,
		input logic [COEF_W-1:0] cy,
		input logic [COEF_W-1:0] off,
		input logic [COEF_W-1:0] k,
		input logic [RAW_W-1:0]  rx,
		input logic [RAW_W-1:0]  ry
	);
		longint num;
		longint quo;
		num = longint'($signed(cx)) * longint'(rx) + longint'($signed(cy)) * longint'(ry)
			+ longint'($signed(off));
		quo = num / longint'($signed(k));
		if (quo > 32767)
			quo = 32767;
		if (quo < -32768)
			quo = -32768;
		return quo[COORD_W-1:0];
	endfunction

	// screen point of a new press under the current calibration
	function automatic coord_t map_press(input tpam_pkg::cal_t c,
			input logic [RAW_W-1:0] rx, input logic [RAW_W-1:0] ry);
		coord_t r;
		if (c.divisor == '0) begin
			r.x = '0;
			r.y = '0;
			r.fault = 1'b1;
		end else begin
			r.x = scale_axis(c.coef_xx, c.coef_xy, c.offset_x, c.divisor, rx, ry);
			r.y = scale_axis(c.coef_yx, c.coef_yy, c.offset_y, c.divisor, rx, ry);
			r.fault = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		coord_t due;
		if (!arst_n) begin
			cal_copy = '0;
			cal_copy.divisor = tpam_pkg::DIVISOR_RST;
			phase = PH_IDLE;
			coords_due.delete();
			bad = 0;
			fail_count <= 0;
			due_count <= 0;
		end else begin
			// calibration write, indexes past the last register do nothing
			if (cfg_we) begin
				case (cfg_idx)
					tpam_pkg::REG_COEF_XX:  cal_copy.coef_xx  = cfg_wdata;
					tpam_pkg::REG_COEF_XY:  cal_copy.coef_xy  = cfg_wdata;
					tpam_pkg::REG_OFFSET_X: cal_copy.offset_x = cfg_wdata;
					tpam_pkg::REG_COEF_YX:  cal_copy.coef_yx  = cfg_wdata;
					tpam_pkg::REG_COEF_YY:  cal_copy.coef_yy  = cfg_wdata;
					tpam_pkg::REG_OFFSET_Y: cal_copy.offset_y = cfg_wdata;
					tpam_pkg::REG_DIVISOR:  cal_copy.divisor  = cfg_wdata;
					default: ;
				endcase
			end

			// poll beat: advance the press phase, queue a point on a new press
			if (push && !full) begin
				case (phase)
					PH_IDLE: begin
						if (pen_down) begin
							coords_due.push_back(map_press(cal_copy, raw_x, raw_y));
							phase = PH_PRESSING;
						end
					end
					PH_PRESSING: phase = pen_down ? PH_HELD : PH_IDLE;
					default: begin
						if (!pen_down)
							phase = PH_IDLE;
					end
				endcase
			end

			// result beat against the oldest point due
			if (pop && !empty) begin
				if (coords_due.size() == 0) begin
					bad++;
					$error("result beat with no press due: x %0d y %0d fault %0b",
						$signed(screen_x), $signed(screen_y), divide_fault);
				end else begin
					due = coords_due.pop_front();
					if (screen_x !== due.x) begin
						bad++;
						$error("screen_x: expected %0d, got %0d",
							$signed(due.x), $signed(screen_x));
					end
					if (screen_y !== due.y) begin
						bad++;
						$error("screen_y: expected %0d, got %0d",
							$signed(due.y), $signed(screen_y));
					end
					if (divide_fault !== due.fault) begin
						bad++;
						$error("divide_fault: expected %0b, got %0b", due.fault, divide_fault);
					end
				end
			end

			fail_count <= bad;
			due_count <= coords_due.size();
		end
	end

endmodule

// ===== bench/touch_press_affine_mapper_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_press_affine_mapper_unit_test - bench top of the touch mapper
// Drives poll beats and calibration writes into the mapper, pops results
// with random stalls and a long hold-off, and lets the press checker
// judge every result. Directed corner presses come first, then random
// press sequences under a series of calibrations.
// ----------------------------------------------------------------------------
module touch_press_affine_mapper_unit_test;

	localparam int RAW_W     = tpam_pkg::RAW_W;
	localparam int COORD_W   = tpam_pkg::COORD_W;
	localparam int COEF_W    = tpam_pkg::COEF_W;
	localparam int REG_IDX_W = tpam_pkg::REG_IDX_W;

	localparam int LIMIT_CYCLES = 1000000;
	// settle padding, well past the time the back end needs for a press
	localparam int SETTLE_PAD   = 100;
	localparam int LONG_HOLD    = 400;
	localparam int RAND_PHASES  = 10;
	localparam int PHASE_POLLS  = 140;

	// index past the last calibration register, writes to it are dropped
	localparam logic [REG_IDX_W-1:0] REG_NONE = 3'd7;

	localparam logic [COEF_W-1:0] W_MAX = 32'h7fff_ffff;
	localparam logic [COEF_W-1:0] W_MIN = 32'h8000_0000;
	localparam logic [COEF_W-1:0] W_M1  = 32'hffff_ffff;

	typedef enum int {
		CAL_PANEL,
		CAL_WILD,
		CAL_CORNER,
		CAL_NODIV
	} cal_kind_t;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic                 pen_down;
	logic [RAW_W-1:0]     raw_x;
	logic [RAW_W-1:0]     raw_y;
	logic                 empty;
	logic                 pop;
	logic [COORD_W-1:0]   screen_x;
	logic [COORD_W-1:0]   screen_y;
	logic                 divide_fault;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_idx;
	logic [COEF_W-1:0]    cfg_wdata;

	int fail_count;
	int due_count;
	int cycles = 0;
	int polls_sent = 0;
	int hold_reqs = 0;
	bit idle_on = 1'b1;

	touch_press_affine_mapper_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.pen_down     (pen_down),
		.raw_x        (raw_x),
		.raw_y        (raw_y),
		.empty        (empty),
		.pop          (pop),
		.screen_x     (screen_x),
		.screen_y     (screen_y),
		.divide_fault (divide_fault),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata)
	);

	tpam_press_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.pen_down     (pen_down),
		.raw_x        (raw_x),
		.raw_y        (raw_y),
		.empty        (empty),
		.pop          (pop),
		.screen_x     (screen_x),
		.screen_y     (screen_y),
		.divide_fault (divide_fault),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.due_count    (due_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("touch_press_affine_mapper_unit_test NOT OK");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		int stall_left;
		int hold_seen;
		pop = 1'b0;
		stall_left = 0;
		hold_seen = 0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				stall_left = $urandom_range(1, 14) - 1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// raw sample, now and then pinned to an end of the range
	function automatic logic [RAW_W-1:0] pick_raw();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return RAW_W'($urandom());
		endcase
	endfunction

	// value in [-lim, lim] as a register word
	function automatic logic [COEF_W-1:0] spread(input int lim);
		return COEF_W'(int'($urandom_range(0, 2 * lim)) - lim);
	endfunction

	function automatic logic [COEF_W-1:0] corner_word();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 32'd1;
			2: return W_M1;
			3: return W_MAX;
			default: return W_MIN;
		endcase
	endfunction

	// one poll beat, with an optional gap ahead of it
	task automatic send_poll(input logic pen, input logic [RAW_W-1:0] rx,
			input logic [RAW_W-1:0] ry);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		push <= 1'b1;
		pen_down <= pen;
		raw_x <= rx;
		raw_y <= ry;
		@(posedge clk);
		while (full)
			@(posedge clk);
		polls_sent++;
	endtask

	// stop sending until every result is out and the back end is quiet
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		@(posedge clk);
		while (due_count != 0)
			@(posedge clk);
		repeat (SETTLE_PAD) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_cal(input logic [COEF_W-1:0] xx, input logic [COEF_W-1:0] xy,
			input logic [COEF_W-1:0] ox, input logic [COEF_W-1:0] yx,
			input logic [COEF_W-1:0] yy, input logic [COEF_W-1:0] oy,
			input logic [COEF_W-1:0] dv);
		write_reg(tpam_pkg::REG_COEF_XX, xx);
		write_reg(tpam_pkg::REG_COEF_XY, xy);
		write_reg(tpam_pkg::REG_OFFSET_X, ox);
		write_reg(tpam_pkg::REG_COEF_YX, yx);
		write_reg(tpam_pkg::REG_COEF_YY, yy);
		write_reg(tpam_pkg::REG_OFFSET_Y, oy);
		write_reg(tpam_pkg::REG_DIVISOR, dv);
	endtask

	task automatic load_random_cal(input cal_kind_t kind);
		int span;
		logic [COEF_W-1:0] dv;
		case (kind)
			// panel-like: quotients mostly inside the coordinate range
			CAL_PANEL: begin
				span = $urandom_range(1, 1 << 20);
				dv = $urandom_range(0, 1) ? COEF_W'(span) : COEF_W'(-span);
				load_cal(spread(span / 4), spread(span / 4), spread(span * 400),
					spread(span / 4), spread(span / 4), spread(span * 400), dv);
			end
			CAL_WILD: begin
				load_cal($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom());
			end
			CAL_CORNER: begin
				load_cal(corner_word(), corner_word(), corner_word(), corner_word(),
					corner_word(), corner_word(), corner_word());
			end
			default: begin
				load_cal($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), '0);
			end
		endcase
	endtask

	// mostly clean press sequences, some random pen noise
	task automatic run_polls(input int count);
		int stop;
		stop = polls_sent + count;
		while (polls_sent < stop) begin
			if ($urandom_range(0, 99) < 85) begin
				repeat ($urandom_range(1, 3)) send_poll(1'b0, pick_raw(), pick_raw());
				repeat ($urandom_range(1, 6)) send_poll(1'b1, pick_raw(), pick_raw());
			end else begin
				repeat ($urandom_range(1, 4))
					send_poll(1'($urandom_range(0, 1)), pick_raw(), pick_raw());
			end
		end
	endtask

	initial begin
		cal_kind_t plan [RAND_PHASES];
		plan = '{CAL_PANEL, CAL_WILD, CAL_PANEL, CAL_CORNER, CAL_PANEL, CAL_NODIV,
			CAL_WILD, CAL_CORNER, CAL_PANEL, CAL_PANEL};

		arst_n = 1'b0;
		push = 1'b0;
		pen_down = 1'b0;
		raw_x = '0;
		raw_y = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset calibration, full press cycle through held
		send_poll(1'b1, '0, '0);
		send_poll(1'b1, 12'd100, 12'd200);
		send_poll(1'b1, '1, '1);
		send_poll(1'b0, '0, '0);

		// identity mapping, raw extremes, pressing straight back to idle
		settle();
		load_cal(32'd1, '0, '0, '0, 32'd1, '0, 32'd1);
		send_poll(1'b1, '1, '1);
		send_poll(1'b0, '0, '0);
		send_poll(1'b1, '1, '0);
		send_poll(1'b0, '0, '0);

		// write past the last register must leave the mapping alone
		settle();
		write_reg(REG_NONE, W_MAX);
		send_poll(1'b1, '0, '1);
		send_poll(1'b0, '0, '0);

		// zero divisor gives a fault with zero coordinates
		settle();
		write_reg(tpam_pkg::REG_DIVISOR, '0);
		send_poll(1'b1, '1, '1);
		send_poll(1'b0, '0, '0);

		// clamp high and low
		settle();
		load_cal(W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN, 32'd1);
		send_poll(1'b1, '1, '1);
		send_poll(1'b0, '0, '0);

		// negative divisor swaps the clamps
		settle();
		write_reg(tpam_pkg::REG_DIVISOR, W_M1);
		send_poll(1'b1, '1, '1);
		send_poll(1'b0, '0, '0);

		// largest divisors of either sign
		settle();
		write_reg(tpam_pkg::REG_DIVISOR, W_MIN);
		send_poll(1'b1, '1, '1);
		send_poll(1'b0, '0, '0);
		settle();
		write_reg(tpam_pkg::REG_DIVISOR, W_MAX);
		send_poll(1'b1, '1, '0);
		send_poll(1'b0, '0, '0);

		// random press traffic under a series of calibrations
		for (int p = 0; p < RAND_PHASES; p++) begin
			settle();
			if (p >= RAND_PHASES - 2)
				idle_on = 1'b0;
			load_random_cal(plan[p]);
			if (p == 2) begin
				// results stay unpopped while presses keep coming, input backs up
				hold_reqs++;
				repeat (12) begin
					send_poll(1'b1, pick_raw(), pick_raw());
					send_poll(1'b0, pick_raw(), pick_raw());
				end
			end
			run_polls(PHASE_POLLS);
		end

		settle();
		if (fail_count == 0)
			$display("touch_press_affine_mapper_unit_test OK");
		else
			$display("touch_press_affine_mapper_unit_test NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/tpam_pkg.sv
design/tpam_job_q.sv
design/tpam_front.sv
design/tpam_back.sv
design/touch_press_affine_mapper_unit.sv
bench/tpam_press_checker.sv
bench/touch_press_affine_mapper_unit_test.sv
